FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the k-nearest point select block.
// Depends on nothing; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the given reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the default clock and reset of the module.
`define ASSERT(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/knps_pkg.sv
// Shared types, constants and width helpers of the k-nearest point select block.
// Depends on nothing; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package knps_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned MAX_PICKS      = 64;
  localparam int unsigned SLOT_IDX_W     = 6;
  localparam int unsigned WANT_W         = 7;
  localparam int unsigned DIST_W         = 50;
  localparam int unsigned RANK_MAX_W     = 64;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic  clr;
    logic  acc_add;
    axis_e axis;
    logic  mark;
  } cell_ctrl_t;

  // Control part of the running-minimum token that walks the chain.
  typedef struct packed {
    logic live;
    logic have;
    logic more;
  } tok_flags_t;

  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int unsigned acc_width(input int unsigned cb);
    return (2 * cb + 2 > RANK_MAX_W) ? RANK_MAX_W : 2 * cb + 2;
  endfunction

endpackage

FILE: hdl/knps_req_if.sv
// Request channel of the k-nearest point select block: valid/ready plus payload.
// Depends on knps_pkg for field widths and the default coordinate width.
`timescale 1ns / 1ps

interface knps_req_if
  import knps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [SLOT_IDX_W-1:0]        slot_index;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [WANT_W-1:0]            want_count;

  modport source (
    output valid, operation, slot_index, pos_x, pos_y, pos_z, want_count,
    input  ready
  );

  modport sink (
    input  valid, operation, slot_index, pos_x, pos_y, pos_z, want_count,
    output ready
  );
endinterface

FILE: hdl/knps_rsp_if.sv
// Result channel of the k-nearest point select block: valid/ready plus payload.
// Depends on knps_pkg for field widths.
`timescale 1ns / 1ps

interface knps_rsp_if
  import knps_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] found_index;
  logic [DIST_W-1:0]     distance_squared;
  logic                  last;

  modport source (
    output valid, found_index, distance_squared, last,
    input  ready
  );

  modport sink (
    input  valid, found_index, distance_squared, last,
    output ready
  );
endinterface

FILE: hdl/k_nearest_point_select.sv
// k_nearest_point_select: keeps NUM_SLOTS 3D points and returns the k nearest
// ones to a query point, nearest first, ties to the lowest slot.
// Channels: req_i (sink) carries load and query requests; rsp_o (source)
// carries one result per picked slot, with last set on the final one.
// A load request completes in the accepting cycle and gives no result. A query with a count of
// zero returns to idle at once with no result.
// A query first forms all squared distances (one shared axis sequence, one
// multiplier per cell), then makes one walk per pick: the running-minimum
// token walks the cell chain one cell per cycle, and the winner is marked
// chosen before the next walk starts. One request is in work at a time.
// The last result sits in an output register, so the next request is taken
// while it waits. A stalled receiver holds the sequencer in its emit state.
// Reset clears all valid marks, chosen marks and handshake state; the point
// coordinates are undefined until written.
// Depends on knps_pkg, knps_req_if, knps_rsp_if, knps_cell, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module k_nearest_point_select
  import knps_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  knps_req_if.sink          req_i,
  knps_rsp_if.source        rsp_o
);

  localparam int unsigned IW         = idx_width(NUM_SLOTS);
  localparam int unsigned ACCW       = acc_width(COORD_BITS);
  localparam int unsigned PICK_LIMIT = (MAX_PICKS < NUM_SLOTS) ? MAX_PICKS : NUM_SLOTS;
  localparam int unsigned PW         = $clog2(PICK_LIMIT + 1);

  state_e                       state_q, state_d;
  logic [2:0]                   dcnt_q, dcnt_d;
  logic [PW-1:0]                left_q, left_d;
  logic                         launch_q, launch_d;
  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [ACCW-1:0]              res_dist_q;
  logic [IW-1:0]                res_idx_q;
  logic                         res_more_q;
  logic                         out_valid_q, out_valid_d;
  logic [SLOT_IDX_W-1:0]        out_idx_q;
  logic [DIST_W-1:0]            out_dist_q;
  logic                         out_last_q;

  logic                         req_fire;
  logic                         is_query;
  logic                         is_load;
  logic [PW-1:0]                want_c;
  logic                         scan_done;
  logic                         last_pick;
  logic                         emit_fire;
  logic [DIST_W-1:0]            dist_sat;
  cell_ctrl_t                   ctrl;
  logic signed [COORD_BITS-1:0] q_coord;

  tok_flags_t                   flags [NUM_SLOTS+1];
  logic [ACCW-1:0]              tdist [NUM_SLOTS+1];
  logic [IW-1:0]                tidx  [NUM_SLOTS+1];

  // Accept only while idle; loads complete in the accepting cycle.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_query    = (op_e'(req_i.operation) == OP_QUERY);
  assign is_load     = (op_e'(req_i.operation) == OP_LOAD);

  // Clamp the count to what the table can ever deliver.
  assign want_c = (int'(req_i.want_count) > int'(PICK_LIMIT)) ? PW'(PICK_LIMIT)
                                                                : PW'(req_i.want_count);

  // Token at the chain end carries the winner of one walk.
  assign scan_done = (state_q == ST_SCAN) && flags[NUM_SLOTS].live;
  assign last_pick = (left_q == PW'(1)) || !res_more_q;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || rsp_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && is_query && (want_c != '0)) state_d = ST_DIST;
      end
      ST_DIST: begin
        if (dcnt_q == 3'd4) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = flags[NUM_SLOTS].have ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_fire) state_d = last_pick ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    ctrl.clr     = req_fire && is_query;
    ctrl.acc_add = (state_q == ST_DIST) && (dcnt_q >= 3'd2);
    ctrl.mark    = emit_fire;
    case (dcnt_q)
      3'd0:    ctrl.axis = AXIS_X;
      3'd1:    ctrl.axis = AXIS_Y;
      3'd2:    ctrl.axis = AXIS_Z;
      default: ctrl.axis = AXIS_X;
    endcase
    case (ctrl.axis)
      AXIS_X:  q_coord = qx_q;
      AXIS_Y:  q_coord = qy_q;
      AXIS_Z:  q_coord = qz_q;
      default: q_coord = qx_q;
    endcase

    dcnt_d = (state_q == ST_DIST) ? dcnt_q + 3'd1 : 3'd0;

    // Launch a walk right after the distances settle, and after each non-final pick.
    launch_d = ((state_q == ST_DIST) && (dcnt_q == 3'd4)) || (emit_fire && !last_pick);

    if (req_fire && is_query) begin
      left_d = want_c;
    end else if (emit_fire) begin
      left_d = left_q - PW'(1);
    end else begin
      left_d = left_q;
    end

    // Output register: load on a pick, drop once taken.
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    dist_sat = (res_dist_q > ACCW'(DIST_MAX)) ? DIST_MAX : DIST_W'(res_dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dcnt_q      <= 3'd0;
      left_q      <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      left_q      <= left_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: query point, pick result, output item.
  always_ff @(posedge clk_i) begin
    if (req_fire && is_query) begin
      qx_q <= req_i.pos_x;
      qy_q <= req_i.pos_y;
      qz_q <= req_i.pos_z;
    end
    if (scan_done) begin
      res_dist_q <= tdist[NUM_SLOTS];
      res_idx_q  <= tidx[NUM_SLOTS];
      res_more_q <= flags[NUM_SLOTS].more;
    end
    if (emit_fire) begin
      out_idx_q  <= SLOT_IDX_W'(res_idx_q);
      out_dist_q <= dist_sat;
      out_last_q <= last_pick;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.found_index      = out_idx_q;
  assign rsp_o.distance_squared = out_dist_q;
  assign rsp_o.last             = out_last_q;

  // Chain head: an empty token, live only on launch.
  assign flags[0] = '{live: launch_q, have: 1'b0, more: 1'b0};
  assign tdist[0] = '0;
  assign tidx[0]  = '0;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    knps_cell #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COORD_BITS (COORD_BITS),
      .IDX        (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .q_coord_i  (q_coord),
      .mark_idx_i (res_idx_q),
      .load_en_i  (req_fire && is_load),
      .load_idx_i (req_i.slot_index),
      .load_x_i   (req_i.pos_x),
      .load_y_i   (req_i.pos_y),
      .load_z_i   (req_i.pos_z),
      .flags_i    (flags[k]),
      .dist_i     (tdist[k]),
      .idx_i      (tidx[k]),
      .flags_o    (flags[k+1]),
      .dist_o     (tdist[k+1]),
      .idx_o      (tidx[k+1])
    );
  end

  // A new result only comes out of the emit state.
  `ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT, "result without pick")
  // A walk is only launched as the sequencer enters the scan state.
  `ASSERT(a_launch_in_scan, launch_q |-> state_q == ST_SCAN, "walk launched outside scan")
  // A finished walk never arrives while the sequencer is elsewhere.
  `ASSERT(a_token_in_scan, flags[NUM_SLOTS].live |-> state_q == ST_SCAN, "stray token at chain end")
  // Emitting with no picks left would overrun the requested count.
  `ASSERT(a_left_in_emit, state_q == ST_EMIT |-> left_q != '0, "emit with no picks left")

endmodule

FILE: hdl/knps_cell.sv
// One slot cell of the k-nearest point select chain: point, marks, distance unit
// and one stage of the running-minimum chain. Depends on knps_pkg.
`timescale 1ns / 1ps

module knps_cell
  import knps_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [COORD_BITS-1:0]  q_coord_i,
  input  logic [idx_width(NUM_SLOTS)-1:0] mark_idx_i,
  input  logic                          load_en_i,
  input  logic [SLOT_IDX_W-1:0]         load_idx_i,
  input  logic signed [COORD_BITS-1:0]  load_x_i,
  input  logic signed [COORD_BITS-1:0]  load_y_i,
  input  logic signed [COORD_BITS-1:0]  load_z_i,
  input  tok_flags_t                    flags_i,
  input  logic [acc_width(COORD_BITS)-1:0] dist_i,
  input  logic [idx_width(NUM_SLOTS)-1:0]  idx_i,
  output tok_flags_t                    flags_o,
  output logic [acc_width(COORD_BITS)-1:0] dist_o,
  output logic [idx_width(NUM_SLOTS)-1:0]  idx_o
);

  localparam int unsigned IW   = idx_width(NUM_SLOTS);
  localparam int unsigned ACCW = acc_width(COORD_BITS);
  localparam int unsigned SQW  = 2 * COORD_BITS;
  localparam bit WRITABLE      = (IDX < (1 << SLOT_IDX_W));

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic signed [COORD_BITS-1:0] sel_coord;
  logic [COORD_BITS:0]          diff;
  logic [COORD_BITS:0]          diff_abs;
  logic [COORD_BITS-1:0]        mag_d, mag_q;
  logic [SQW-1:0]               sq_d, sq_q;
  logic [ACCW:0]                sum;
  logic [ACCW-1:0]              acc_d, acc_q;
  logic                         valid_d, valid_q;
  logic                         chosen_d, chosen_q;
  logic                         wr_hit;
  logic                         cand;
  logic                         take_own;
  tok_flags_t                   flags_d, flags_q;
  logic [ACCW-1:0]              dist_d, dist_q;
  logic [IW-1:0]                idx_d, idx_q;

  assign wr_hit = load_en_i && WRITABLE && (load_idx_i == SLOT_IDX_W'(IDX));

  // Axis distance: magnitude of the difference, then its square, then accumulate.
  always_comb begin
    case (ctrl_i.axis)
      AXIS_X:  sel_coord = px_q;
      AXIS_Y:  sel_coord = py_q;
      AXIS_Z:  sel_coord = pz_q;
      default: sel_coord = px_q;
    endcase
    diff     = {sel_coord[COORD_BITS-1], sel_coord} - {q_coord_i[COORD_BITS-1], q_coord_i};
    diff_abs = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    mag_d    = diff_abs[COORD_BITS-1:0];
    sq_d     = SQW'(mag_q) * SQW'(mag_q);
    sum      = {1'b0, acc_q} + (ACCW + 1)'(sq_q);
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_add) begin
      acc_d = sum[ACCW] ? '1 : sum[ACCW-1:0];
    end else begin
      acc_d = acc_q;
    end
  end

  // Running minimum: strict less keeps the lower index on ties.
  always_comb begin
    cand     = valid_q && !chosen_q;
    take_own = cand && (!flags_i.have || (acc_q < dist_i));
    flags_d.live = flags_i.live;
    flags_d.have = flags_i.have || cand;
    flags_d.more = flags_i.more || (flags_i.have && cand);
    dist_d   = take_own ? acc_q : dist_i;
    idx_d    = take_own ? IW'(IDX) : idx_i;
    valid_d  = valid_q || wr_hit;
    if (ctrl_i.clr) begin
      chosen_d = 1'b0;
    end else if (ctrl_i.mark && (mark_idx_i == IW'(IDX))) begin
      chosen_d = 1'b1;
    end else begin
      chosen_d = chosen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      chosen_q <= 1'b0;
      flags_q  <= '0;
    end else begin
      valid_q  <= valid_d;
      chosen_q <= chosen_d;
      flags_q  <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      px_q <= load_x_i;
      py_q <= load_y_i;
      pz_q <= load_z_i;
    end
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    dist_q <= dist_d;
    idx_q  <= idx_d;
  end

  assign flags_o = flags_q;
  assign dist_o  = dist_q;
  assign idx_o   = idx_q;

endmodule

FILE: tb/tb.sv
// Testbench for k_nearest_point_select: loads points, issues nearest-point queries
// and checks every result against an in-bench ranking of the loaded points.
// Depends on knps_pkg, knps_req_if, knps_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb
  import knps_pkg::*;
;

  localparam int unsigned NUM_SLOTS  = NUM_SLOTS_DEF;
  localparam int unsigned COORD_BITS = COORD_BITS_DEF;

  // Random stimulus size and run bounds. The cycle limit covers every request
  // asking for all slots with each result held up by the receiver, several times over.
  localparam int RANDOM_ITEMS = 84;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 4 * (NUM_SLOTS + 2) + 20;
  localparam int IDLE_PCT     = 19;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // One expected result: picked slot, its squared distance, end-of-query mark.
  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic [DIST_W-1:0]     dist_sq;
    logic                  last;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  knps_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
  knps_rsp_if                            rsp_if ();

  k_nearest_point_select #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the point table, updated in request order.
  coord_t slot_pos_x [NUM_SLOTS];
  coord_t slot_pos_y [NUM_SLOTS];
  coord_t slot_pos_z [NUM_SLOTS];
  bit     slot_live  [NUM_SLOTS];

  pick_t  nearest_expected [$];

  int     mismatches      = 0;
  int     loads_sent      = 0;
  int     queries_sent    = 0;
  int     results_checked = 0;
  int     cycle_count     = 0;

  // Gap control for each side, and the long receiver hold-off request.
  bit     src_steady = 1'b0;
  bit     snk_steady = 1'b0;
  int     hold_req   = 0;
  int     hold_left  = 0;

  // Last loaded point, reused as a query point to hit zero distance.
  coord_t recent_x, recent_y, recent_z;

  // Squared distance along one axis; the difference needs one extra bit.
  function automatic logic [63:0] axis_sq(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] diff;
    logic [63:0]                mag;
    diff = a - b;
    mag  = (diff < 0) ? -diff : diff;
    return mag * mag;
  endfunction

  // Rank the live slots against the query point and queue the picks,
  // nearest first, lowest slot on equal distance.
  function automatic void rank_nearest(coord_t qx, coord_t qy, coord_t qz,
                                       logic [WANT_W-1:0] want);
    int          limit;
    bit          taken [NUM_SLOTS];
    bit          found;
    int          best;
    logic [63:0] best_d;
    logic [63:0] d;
    pick_t       picks [$];
    pick_t       p;
    limit = want;
    if (limit > MAX_PICKS) limit = MAX_PICKS;
    if (limit > NUM_SLOTS) limit = NUM_SLOTS;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int n = 0; n < limit; n++) begin
      found  = 1'b0;
      best   = 0;
      best_d = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_live[i] && !taken[i]) begin
          d = axis_sq(slot_pos_x[i], qx) + axis_sq(slot_pos_y[i], qy)
              + axis_sq(slot_pos_z[i], qz);
          if (!found || d < best_d) begin
            found  = 1'b1;
            best   = i;
            best_d = d;
          end
        end
      end
      if (!found) break;
      taken[best] = 1'b1;
      p.slot    = best[SLOT_IDX_W-1:0];
      p.dist_sq = (best_d > DIST_MAX) ? DIST_MAX : best_d[DIST_W-1:0];
      p.last    = 1'b0;
      picks.push_back(p);
    end
    if (picks.size() > 0) picks[picks.size()-1].last = 1'b1;
    foreach (picks[i]) nearest_expected.push_back(picks[i]);
  endfunction

  // Offer one request from a falling edge, hold it until accepted, then
  // update the shadow table. Return aligned to the next falling edge with
  // valid still high, so back-to-back requests never drop it.
  task automatic send_req(op_e op, logic [SLOT_IDX_W-1:0] slot,
                          coord_t x, coord_t y, coord_t z,
                          logic [WANT_W-1:0] want);
    if (!src_steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    req_if.operation  = op;
    req_if.slot_index = slot;
    req_if.pos_x      = x;
    req_if.pos_y      = y;
    req_if.pos_z      = z;
    req_if.want_count = want;
    req_if.valid      = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OP_LOAD) begin
      slot_pos_x[slot] = x;
      slot_pos_y[slot] = y;
      slot_pos_z[slot] = z;
      slot_live[slot]  = 1'b1;
      loads_sent++;
    end else begin
      rank_nearest(x, y, z, want);
      queries_sent++;
    end
    @(negedge clk_i);
  endtask

  // A load ignores want_count, so fill it with noise.
  task automatic load_point(logic [SLOT_IDX_W-1:0] slot, coord_t x, coord_t y, coord_t z);
    recent_x = x;
    recent_y = y;
    recent_z = z;
    send_req(OP_LOAD, slot, x, y, z, WANT_W'($urandom));
  endtask

  // A query ignores slot_index, so fill it with noise.
  task automatic query_points(coord_t x, coord_t y, coord_t z, logic [WANT_W-1:0] want);
    send_req(OP_QUERY, SLOT_IDX_W'($urandom), x, y, z, want);
  endtask

  // Mix full-range values with a tight cluster (ties) and the extremes.
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5, 6, 7: return coord_t'($signed($urandom_range(8)) - 4);
      8:          return $urandom_range(1) ? C_MAX : C_MIN;
      default:    return coord_t'($signed($urandom_range(2)) - 1);
    endcase
  endfunction

  // Mostly small counts; some zero, some past the slot count.
  function automatic logic [WANT_W-1:0] rand_want();
    case ($urandom_range(19))
      0, 1:    return '0;
      13, 14, 15: return WANT_W'($urandom_range(40, 7));
      16, 17:  return WANT_W'($urandom_range(64, 41));
      18, 19:  return WANT_W'($urandom_range(127, 65));
      default: return WANT_W'($urandom_range(6, 1));
    endcase
  endfunction

  // Query before any load: nothing is valid, so nothing comes back.
  task automatic test_empty_table();
    query_points('0, '0, '0, 7'd5);
    query_points(C_MAX, C_MIN, '0, 7'd64);
  endtask

  // Points at the corners of the coordinate range give the largest distances.
  task automatic test_extreme_points();
    load_point(6'd0, C_MAX, C_MAX, C_MAX);
    load_point(6'd63, C_MIN, C_MIN, C_MIN);
    query_points(C_MIN, C_MIN, C_MIN, 7'd2);
    query_points(C_MAX, C_MAX, C_MAX, 7'd3);
    query_points(C_MAX, C_MIN, '0, 7'd1);
    query_points('0, '0, '0, 7'd0);
  endtask

  // Equal distances must come out in slot order, whatever the load order;
  // an overwrite must replace the old point; counts clamp at the slot count.
  task automatic test_ties_and_counts();
    load_point(6'd9, 24'sd2, 24'sd0, 24'sd0);
    load_point(6'd2, 24'sd0, 24'sd0, 24'sd0);
    load_point(6'd5, 24'sd1, 24'sd1, 24'sd0);
    query_points(24'sd1, 24'sd0, 24'sd0, 7'd127);
    load_point(6'd9, 24'sd1, 24'sd0, 24'sd0);
    query_points(24'sd1, 24'sd0, 24'sd0, 7'd2);
    query_points(24'sd1, 24'sd0, 24'sd0, 7'd64);
    query_points(-24'sd1, 24'sd0, 24'sd0, 7'd1);
    query_points(24'sd1, 24'sd0, 24'sd0, 7'd0);
    query_points(24'sd3, -24'sd2, 24'sd5, 7'd65);
  endtask

  // Well-formed bursts (a few loads, then queries, some at the last loaded point) with some lone
  // noise requests; the middle stretch runs with no gaps on either side.
  task automatic test_random_mix();
    int sent;
    int n_load;
    int n_ask;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_steady = (sent >= 40 && sent < 70);
      snk_steady = src_steady;
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1))
          query_points(rand_coord(), rand_coord(), rand_coord(), rand_want());
        else
          load_point(SLOT_IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
        sent++;
      end else begin
        n_load = $urandom_range(4, 1);
        n_ask  = $urandom_range(2, 1);
        repeat (n_load) begin
          load_point(SLOT_IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
          sent++;
        end
        repeat (n_ask) begin
          if ($urandom_range(2) == 0)
            query_points(recent_x, recent_y, recent_z, rand_want());
          else
            query_points(rand_coord(), rand_coord(), rand_coord(), rand_want());
          sent++;
        end
      end
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  // Hold off the receiver for a long stretch while queries keep coming, so
  // the block fills its output and stalls its request input.
  task automatic test_output_stall();
    src_steady = 1'b1;
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (8) query_points(rand_coord(), rand_coord(), rand_coord(), 7'd3);
    src_steady = 1'b0;
  endtask

  // Receiver: drive ready at the falling edge. A hold-off request wins,
  // then the gap-free mode, else idle at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready = 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      rsp_if.ready = 1'b0;
      hold_left    = hold_req - 1;
      hold_req     = 0;
    end else if (snk_steady) begin
      rsp_if.ready = 1'b1;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each accepted result against the oldest expected pick.
  always @(posedge clk_i) begin : result_check
    pick_t exp_pick;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (nearest_expected.size() == 0) begin
        $error("unexpected result: found_index %0d distance_squared %0d last %0b",
               rsp_if.found_index, rsp_if.distance_squared, rsp_if.last);
        mismatches++;
      end else begin
        exp_pick = nearest_expected.pop_front();
        if (rsp_if.found_index !== exp_pick.slot) begin
          $error("found_index: expected %0d, actual %0d", exp_pick.slot, rsp_if.found_index);
          mismatches++;
        end
        if (rsp_if.distance_squared !== exp_pick.dist_sq) begin
          $error("distance_squared: expected %0d, actual %0d",
                 exp_pick.dist_sq, rsp_if.distance_squared);
          mismatches++;
        end
        if (rsp_if.last !== exp_pick.last) begin
          $error("last: expected %0b, actual %0b", exp_pick.last, rsp_if.last);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still expected",
             cycle_count, nearest_expected.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    recent_x          = '0;
    recent_y          = '0;
    recent_z          = '0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_LOAD;
    req_if.slot_index = '0;
    req_if.pos_x      = '0;
    req_if.pos_y      = '0;
    req_if.pos_z      = '0;
    req_if.want_count = '0;
    rsp_if.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_extreme_points();
    test_ties_and_counts();
    test_random_mix();
    test_output_stall();

    // Drop valid, drain every expected pick, then give a trailing query
    // that returns nothing time to finish.
    req_if.valid = 1'b0;
    while (nearest_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads and %0d queries (%0d picks checked) in %0d cycles,",
             loads_sent, queries_sent, results_checked, cycle_count);
    $display("incl. empty table, range extremes, ties, count clamps and output stall.");
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
